/* hw/rtl/grid_dda_raycaster_top_macros.svh */
// Assertion macros shared by the raycaster modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef GRID_DDA_RAYCASTER_TOP_MACROS_SVH
`define GRID_DDA_RAYCASTER_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gdr_pkg.sv */
package gdr_pkg;

  // Default map size in tiles.
  localparam int MAP_ROWS_DEF = 64;
  localparam int MAP_COLS_DEF = 64;
  // Row pitch of the map store in entries.
  localparam int MAP_PITCH = 64;

  // Serial divider word width.
  localparam int DIV_W = 32;

  // Distance format Q8.16 and its saturation value.
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFF_FFFF;
  // Line height saturation value.
  localparam logic [11:0] LINE_MAX = 12'd4095;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POS_X    = 3'd0;
  localparam logic [2:0] CFG_POS_Y    = 3'd1;
  localparam logic [2:0] CFG_DIR_X    = 3'd2;
  localparam logic [2:0] CFG_DIR_Y    = 3'd3;
  localparam logic [2:0] CFG_PLANE_X  = 3'd4;
  localparam logic [2:0] CFG_PLANE_Y  = 3'd5;
  localparam logic [2:0] CFG_SCREEN_W = 3'd6;
  localparam logic [2:0] CFG_SCREEN_H = 3'd7;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/gdr_in_if.sv */
interface gdr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic       cell_wall;
  logic [9:0] column;

  modport source (output valid, mode, cell_row, cell_col, cell_wall, column, input ready);
  modport sink (input valid, mode, cell_row, cell_col, cell_wall, column, output ready);
endinterface

/* hw/rtl/gdr_out_if.sv */
interface gdr_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        column_res;
  logic signed [11:0] start_row;
  logic [11:0]       wall_height;
  logic              hit_side;
  logic              left_map;

  modport source (output valid, column_res, start_row, wall_height, hit_side, left_map,
                  input ready);
  modport sink (input valid, column_res, start_row, wall_height, hit_side, left_map,
                output ready);
endinterface

/* hw/rtl/gdr_ram.sv */
module gdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One port: registered read, and a write when we is set, at the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/gdr_div.sv */
`include "grid_dda_raycaster_top_macros.svh"

module gdr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gdr_pkg::div_req_t req,
  output gdr_pkg::div_rsp_t rsp
);

  localparam int W = gdr_pkg::DIV_W;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [$clog2(W)-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         quo_r, quo_nxt;
  logic [W-1:0]         den_r, den_nxt;
  logic [W:0]           trial;
  logic [W:0]           diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(W))'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  `GDR_ASSERT_NOW(a_div_start_idle, req.start, !busy_r, "divider started while busy")
  `GDR_ASSERT_NOW(a_div_done_idle, done_r, !busy_r, "divider done while still busy")
  `GDR_ASSERT_NEXT(a_div_start_busy, req.start, busy_r, "divider did not begin")

endmodule

/* hw/rtl/grid_dda_raycaster_top.sv */
`include "grid_dda_raycaster_top_macros.svh"

// Column raycaster over a one-bit wall map held in a single-port RAM of
// MAP_ROWS*64 entries. After reset the block sweeps the map to empty, one
// entry per cycle, and takes no item meanwhile. A write item stores one wall
// bit, if its cell lies in the map, and gives no result. A cast item takes
// four runs of the shared serial divider (camera offset, the two reciprocal
// ray components and the line height; each of the last three is skipped for
// a zero component, a zero distance or a zero screen height); it also passes
// through multiply, setup and hand-over states, and for each DDA step through
// one state that steps and addresses the map RAM and one that tests the read
// bit; a step that leaves the map skips the test. A walk takes at most about
// MAP_ROWS+MAP_COLS steps. One item is worked at a time; the result beat sits
// in an output register, so the next item may be taken while it waits.
module grid_dda_raycaster_top #(
  parameter int MAP_ROWS = gdr_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = gdr_pkg::MAP_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_wdata,
  gdr_in_if.sink      in_ch,
  gdr_out_if.source   out_ch
);

  localparam int MAP_DEPTH = MAP_ROWS * gdr_pkg::MAP_PITCH;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int DW        = gdr_pkg::DIST_W;
  localparam int QW        = gdr_pkg::DIV_W;

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_CAMS  = 5'd2;
  localparam logic [4:0] ST_CAMW  = 5'd3;
  localparam logic [4:0] ST_MUL   = 5'd4;
  localparam logic [4:0] ST_RAY   = 5'd5;
  localparam logic [4:0] ST_DXS   = 5'd6;
  localparam logic [4:0] ST_DXW   = 5'd7;
  localparam logic [4:0] ST_DYS   = 5'd8;
  localparam logic [4:0] ST_DYW   = 5'd9;
  localparam logic [4:0] ST_SIDE  = 5'd10;
  localparam logic [4:0] ST_SIDE2 = 5'd11;
  localparam logic [4:0] ST_STEP  = 5'd12;
  localparam logic [4:0] ST_LOOK  = 5'd13;
  localparam logic [4:0] ST_PERP  = 5'd14;
  localparam logic [4:0] ST_LHS   = 5'd15;
  localparam logic [4:0] ST_LHW   = 5'd16;
  localparam logic [4:0] ST_FIN   = 5'd17;

  // Configuration registers.
  logic [21:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [9:0]         scr_w_r, scr_h_r;

  // Control state.
  logic [4:0]   state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic         out_valid_r, out_valid_nxt;

  // Working registers of one cast.
  logic [9:0]         col_r, col_nxt;
  logic signed [26:0] cam_r, cam_nxt;
  logic signed [42:0] prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;
  logic signed [29:0] rdx_r, rdx_nxt, rdy_r, rdy_nxt;
  logic [DW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [40:0]        px_r, px_nxt, py_r, py_nxt;
  logic [DW-1:0]      lx_r, lx_nxt, ly_r, ly_nxt;
  logic signed [7:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic               side_r, side_nxt;
  logic               left_r, left_nxt;
  logic [DW-1:0]      perp_r, perp_nxt;
  logic [11:0]        lh_r, lh_nxt;

  // Result register.
  logic [9:0]         o_col_r, o_col_nxt;
  logic signed [11:0] o_start_r, o_start_nxt;
  logic [11:0]        o_lh_r, o_lh_nxt;
  logic               o_side_r, o_side_nxt;
  logic               o_left_r, o_left_nxt;

  // Map RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;

  // Divider.
  gdr_pkg::div_req_t div_req;
  gdr_pkg::div_rsp_t div_rsp;

  // Combinational helpers.
  logic              in_acc;
  logic              rdx_pos, rdy_pos;
  logic [29:0]       ax, ay;
  logic [24:0]       sum_x, sum_y;
  logic              step_x;
  logic signed [7:0] ncx, ncy;
  logic              outside;
  logic [16:0]       mx, my;
  logic [QW-1:0]     quot;
  logic              res_free;
  logic [11:0]        half_h, half_lh;

  gdr_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  gdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign res_free    = !out_valid_r || out_ch.ready;
  assign quot        = div_rsp.quot;

  // Ray signs and magnitudes.
  assign rdx_pos = !rdx_r[29] && (rdx_r != '0);
  assign rdy_pos = !rdy_r[29] && (rdy_r != '0);
  assign ax      = rdx_r[29] ? 30'(-rdx_r) : 30'(rdx_r);
  assign ay      = rdy_r[29] ? 30'(-rdy_r) : 30'(rdy_r);

  // Fractions toward the first boundary on each axis.
  assign mx = rdx_pos ? (17'h10000 - {1'b0, pos_x_r[15:0]}) : {1'b0, pos_x_r[15:0]};
  assign my = rdy_pos ? (17'h10000 - {1'b0, pos_y_r[15:0]}) : {1'b0, pos_y_r[15:0]};

  // One DDA step: choose the axis, grow its side distance, move the cell.
  assign step_x = lx_r < ly_r;
  assign sum_x  = {1'b0, lx_r} + {1'b0, dx_r};
  assign sum_y  = {1'b0, ly_r} + {1'b0, dy_r};
  assign ncx    = step_x ? (rdx_pos ? cx_r + 8'sd1 : cx_r - 8'sd1) : cx_r;
  assign ncy    = step_x ? cy_r : (rdy_pos ? cy_r + 8'sd1 : cy_r - 8'sd1);
  assign outside = (ncx < 0) || (ncy < 0) || (ncx >= MAP_COLS) || (ncy >= MAP_ROWS);

  assign half_h  = {3'b0, scr_h_r[9:1]};
  assign half_lh = {1'b0, lh_r[11:1]};

  // Map port selection: clearing sweep, cell write, or DDA read.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = AW'({cy_r[5:0], cx_r[5:0]});
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
      end
      ST_IDLE: begin
        ram_addr  = AW'({in_ch.cell_row, in_ch.cell_col});
        ram_wdata = in_ch.cell_wall;
        ram_we    = in_acc && (in_ch.mode == gdr_pkg::MODE_WRITE) &&
                    (32'(in_ch.cell_row) < MAP_ROWS) && (32'(in_ch.cell_col) < MAP_COLS);
      end
      ST_STEP: begin
        ram_addr = AW'({ncy[5:0], ncx[5:0]});
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    col_nxt    = col_r;
    cam_nxt    = cam_r;
    prod_x_nxt = prod_x_r;
    prod_y_nxt = prod_y_r;
    rdx_nxt    = rdx_r;
    rdy_nxt    = rdy_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    lx_nxt     = lx_r;
    ly_nxt     = ly_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    side_nxt   = side_r;
    left_nxt   = left_r;
    perp_nxt   = perp_r;
    lh_nxt     = lh_r;
    o_col_nxt   = o_col_r;
    o_start_nxt = o_start_r;
    o_lh_nxt    = o_lh_r;
    o_side_nxt  = o_side_r;
    o_left_nxt  = o_left_r;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_ch.mode == gdr_pkg::MODE_CAST)) begin
          col_nxt   = in_ch.column;
          state_nxt = ST_CAMS;
        end
      end
      // Camera offset: column * 2^15 / width.
      ST_CAMS: begin
        div_req.start = 1'b1;
        div_req.num   = QW'({col_r, 15'b0});
        div_req.den   = (scr_w_r == '0) ? QW'(1) : QW'(scr_w_r);
        state_nxt     = ST_CAMW;
      end
      ST_CAMW: begin
        if (div_rsp.done) begin
          cam_nxt   = $signed({2'b0, quot[24:0]}) - 27'sd16384;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_x_nxt = plane_x_r * cam_r;
        prod_y_nxt = plane_y_r * cam_r;
        state_nxt  = ST_RAY;
      end
      // Ray direction; the arithmetic shift floors the Q.14 product.
      ST_RAY: begin
        rdx_nxt   = 30'(dir_x_r) + 30'(prod_x_r >>> 14);
        rdy_nxt   = 30'(dir_y_r) + 30'(prod_y_r >>> 14);
        state_nxt = ST_DXS;
      end
      // Reciprocal step lengths; a zero component saturates.
      ST_DXS: begin
        if (ax == '0) begin
          dx_nxt    = gdr_pkg::DIST_MAX;
          state_nxt = ST_DYS;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = QW'(32'h4000_0000);
          div_req.den   = QW'(ax);
          state_nxt     = ST_DXW;
        end
      end
      ST_DXW: begin
        if (div_rsp.done) begin
          dx_nxt    = (quot[QW-1:DW] != '0) ? gdr_pkg::DIST_MAX : quot[DW-1:0];
          state_nxt = ST_DYS;
        end
      end
      ST_DYS: begin
        if (ay == '0) begin
          dy_nxt    = gdr_pkg::DIST_MAX;
          state_nxt = ST_SIDE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = QW'(32'h4000_0000);
          div_req.den   = QW'(ay);
          state_nxt     = ST_DYW;
        end
      end
      ST_DYW: begin
        if (div_rsp.done) begin
          dy_nxt    = (quot[QW-1:DW] != '0) ? gdr_pkg::DIST_MAX : quot[DW-1:0];
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        px_nxt    = 41'(mx) * 41'(dx_r);
        py_nxt    = 41'(my) * 41'(dy_r);
        cx_nxt    = $signed({2'b0, pos_x_r[21:16]});
        cy_nxt    = $signed({2'b0, pos_y_r[21:16]});
        side_nxt  = 1'b0;
        left_nxt  = 1'b0;
        state_nxt = ST_SIDE2;
      end
      ST_SIDE2: begin
        lx_nxt    = px_r[40] ? gdr_pkg::DIST_MAX : px_r[39:16];
        ly_nxt    = py_r[40] ? gdr_pkg::DIST_MAX : py_r[39:16];
        state_nxt = ST_STEP;
      end
      // Step and address the new cell; bounds come before the read.
      ST_STEP: begin
        if (step_x) begin
          lx_nxt   = sum_x[DW] ? gdr_pkg::DIST_MAX : sum_x[DW-1:0];
          side_nxt = 1'b0;
        end else begin
          ly_nxt   = sum_y[DW] ? gdr_pkg::DIST_MAX : sum_y[DW-1:0];
          side_nxt = 1'b1;
        end
        cx_nxt = ncx;
        cy_nxt = ncy;
        if (outside) begin
          left_nxt  = 1'b1;
          state_nxt = ST_PERP;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ram_rdata ? ST_PERP : ST_STEP;
      end
      ST_PERP: begin
        perp_nxt  = side_r ? (ly_r - dy_r) : (lx_r - dx_r);
        state_nxt = ST_LHS;
      end
      // Line height: screen height over distance, saturated.
      ST_LHS: begin
        if (scr_h_r == '0) begin
          lh_nxt    = '0;
          state_nxt = ST_FIN;
        end else if (perp_r == '0) begin
          lh_nxt    = gdr_pkg::LINE_MAX;
          state_nxt = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = QW'({scr_h_r, 16'b0});
          div_req.den   = QW'(perp_r);
          state_nxt     = ST_LHW;
        end
      end
      ST_LHW: begin
        if (div_rsp.done) begin
          lh_nxt    = (quot > QW'(gdr_pkg::LINE_MAX)) ? gdr_pkg::LINE_MAX : quot[11:0];
          state_nxt = ST_FIN;
        end
      end
      // Hand the slice to the output register once it is free.
      ST_FIN: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          o_col_nxt     = col_r;
          o_start_nxt   = $signed(half_h - half_lh);
          o_lh_nxt      = lh_r;
          o_side_nxt    = side_r;
          o_left_nxt    = left_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 22'd131072;
      pos_y_r   <= 22'd131072;
      dir_x_r   <= -16'sd16384;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 16'sd10813;
      scr_w_r   <= 10'd320;
      scr_h_r   <= 10'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        gdr_pkg::CFG_POS_X:    pos_x_r   <= cfg_wdata;
        gdr_pkg::CFG_POS_Y:    pos_y_r   <= cfg_wdata;
        gdr_pkg::CFG_DIR_X:    dir_x_r   <= $signed(cfg_wdata[15:0]);
        gdr_pkg::CFG_DIR_Y:    dir_y_r   <= $signed(cfg_wdata[15:0]);
        gdr_pkg::CFG_PLANE_X:  plane_x_r <= $signed(cfg_wdata[15:0]);
        gdr_pkg::CFG_PLANE_Y:  plane_y_r <= $signed(cfg_wdata[15:0]);
        gdr_pkg::CFG_SCREEN_W: scr_w_r   <= cfg_wdata[9:0];
        gdr_pkg::CFG_SCREEN_H: scr_h_r   <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r    <= col_nxt;
    cam_r    <= cam_nxt;
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    rdx_r    <= rdx_nxt;
    rdy_r    <= rdy_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    lx_r     <= lx_nxt;
    ly_r     <= ly_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    side_r   <= side_nxt;
    left_r   <= left_nxt;
    perp_r   <= perp_nxt;
    lh_r     <= lh_nxt;
    o_col_r   <= o_col_nxt;
    o_start_r <= o_start_nxt;
    o_lh_r    <= o_lh_nxt;
    o_side_r  <= o_side_nxt;
    o_left_r  <= o_left_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.column_res  = o_col_r;
  assign out_ch.start_row   = o_start_r;
  assign out_ch.wall_height = o_lh_r;
  assign out_ch.hit_side    = o_side_r;
  assign out_ch.left_map    = o_left_r;

  `GDR_ASSERT_NOW(a_clear_no_accept, state_r == ST_CLEAR, !in_ch.ready,
    "item taken during clear")
  `GDR_ASSERT_NOW(a_look_in_bounds, state_r == ST_LOOK,
    (cx_r >= 0) && (cy_r >= 0) && (cx_r < MAP_COLS) && (cy_r < MAP_ROWS), "map read out of bounds")
  `GDR_ASSERT_NEXT(a_write_one_cycle, in_acc && (in_ch.mode == gdr_pkg::MODE_WRITE),
    (state_r == ST_IDLE) && !$rose(out_valid_r), "write item changed cast state")

endmodule

/* test/gdr_slice_checker.sv */
// Watches the configuration port and both channels of the raycaster, keeps
// its own copy of the wall map and the camera registers, works out the wall
// slice for every cast beat and compares it with the result beats in order.
module gdr_slice_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_wdata,
  gdr_in_if           in_mon,
  gdr_out_if          out_mon,
  output int          fail_count,
  output int          slices_waiting
);

  typedef struct packed {
    logic [9:0]         column;
    logic signed [11:0] start_row;
    logic [11:0]        wall_height;
    logic               hit_side;
    logic               left_map;
  } slice_t;

  localparam longint DSAT = 64'hFF_FFFF;

  bit                 wall_map [4096];
  logic [21:0]        view_x, view_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [9:0]         scr_w, scr_h;
  slice_t             slice_q [$];

  function automatic longint clamp_dist(longint v);
    return (v > DSAT) ? DSAT : v;
  endfunction

  // Walks one ray through the map and forms the slice it hits.
  function automatic slice_t cast_slice(logic [9:0] col);
    slice_t s;
    longint w, cam, rdx, rdy, ax, ay, dx, dy, cx, cy, fx, fy, sx, sy, lx, ly;
    longint perp, h, lh, top;
    bit     side, left;
    w    = (scr_w == 0) ? 1 : scr_w;
    cam  = ((longint'(col) << 15) / w) - 16384;
    rdx  = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 14);
    rdy  = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 14);
    ax   = (rdx < 0) ? -rdx : rdx;
    ay   = (rdy < 0) ? -rdy : rdy;
    dx   = (ax != 0) ? clamp_dist((longint'(1) << 30) / ax) : DSAT;
    dy   = (ay != 0) ? clamp_dist((longint'(1) << 30) / ay) : DSAT;
    cx   = view_x >> 16;
    cy   = view_y >> 16;
    fx   = view_x & 22'hFFFF;
    fy   = view_y & 22'hFFFF;
    if (rdx > 0) begin
      sx = 1;
      lx = clamp_dist(((65536 - fx) * dx) >> 16);
    end else begin
      sx = -1;
      lx = clamp_dist((fx * dx) >> 16);
    end
    if (rdy > 0) begin
      sy = 1;
      ly = clamp_dist(((65536 - fy) * dy) >> 16);
    end else begin
      sy = -1;
      ly = clamp_dist((fy * dy) >> 16);
    end
    side = 0;
    left = 0;
    // Step the nearer boundary until a wall or the map edge is reached.
    for (int g = 0; g < 512; g++) begin
      if (lx < ly) begin
        lx   = clamp_dist(lx + dx);
        cx   = cx + sx;
        side = 0;
      end else begin
        ly   = clamp_dist(ly + dy);
        cy   = cy + sy;
        side = 1;
      end
      if (cx < 0 || cy < 0 || cx >= 64 || cy >= 64) begin
        left = 1;
        break;
      end
      if (wall_map[(cy * 64 + cx) & 4095]) break;
    end
    perp = side ? ly - dy : lx - dx;
    h    = scr_h;
    if (h == 0) lh = 0;
    else if (perp == 0) lh = 4095;
    else begin
      lh = (h << 16) / perp;
      if (lh > 4095) lh = 4095;
    end
    top = (h >> 1) - (lh >> 1);
    s.column      = col;
    s.start_row   = top[11:0];
    s.wall_height = lh[11:0];
    s.hit_side    = side;
    s.left_map    = left;
    return s;
  endfunction

  always @(posedge clk) begin
    slice_t want;
    slice_t got;
    if (!rst_n) begin
      foreach (wall_map[i]) wall_map[i] = 0;
      view_x     = 22'd131072;
      view_y     = 22'd131072;
      dir_x      = -16'sd16384;
      dir_y      = 16'sd0;
      plane_x    = 16'sd0;
      plane_y    = 16'sd10813;
      scr_w      = 10'd320;
      scr_h      = 10'd240;
      fail_count <= 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          gdr_pkg::CFG_POS_X:    view_x  = cfg_wdata;
          gdr_pkg::CFG_POS_Y:    view_y  = cfg_wdata;
          gdr_pkg::CFG_DIR_X:    dir_x   = cfg_wdata[15:0];
          gdr_pkg::CFG_DIR_Y:    dir_y   = cfg_wdata[15:0];
          gdr_pkg::CFG_PLANE_X:  plane_x = cfg_wdata[15:0];
          gdr_pkg::CFG_PLANE_Y:  plane_y = cfg_wdata[15:0];
          gdr_pkg::CFG_SCREEN_W: scr_w   = cfg_wdata[9:0];
          gdr_pkg::CFG_SCREEN_H: scr_h   = cfg_wdata[9:0];
          default: ;
        endcase
      end
      // Input beats: map writes update the copy, casts queue a slice.
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == gdr_pkg::MODE_WRITE)
          wall_map[in_mon.cell_row * 64 + in_mon.cell_col] = in_mon.cell_wall;
        else
          slice_q.push_back(cast_slice(in_mon.column));
      end
      // Result beats against the oldest queued slice.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.column_res, out_mon.start_row, out_mon.wall_height,
                out_mon.hit_side, out_mon.left_map};
        if (slice_q.size() == 0) begin
          $display("%0t: unexpected slice %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = slice_q.pop_front();
          if (want != got) begin
            $display("%0t: slice mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    slices_waiting <= slice_q.size();
  end
endmodule

/* test/tb_top.sv */
module tb_top;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_wdata;
  logic        calm;
  logic [9:0]  cur_w;
  int          casts_open;
  int          quiet_cycles;
  int          fail_count;
  int          slices_waiting;

  gdr_in_if  in_ch ();
  gdr_out_if out_ch ();

  grid_dda_raycaster_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  gdr_slice_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .slices_waiting (slices_waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side stalls now and then, never in a calm phase.
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // Casts still in flight, and a watchdog on handshake activity.
  always @(posedge clk) begin
    if (!rst_n) begin
      casts_open   <= 0;
      quiet_cycles <= 0;
    end else begin
      casts_open <= casts_open
                    + ((in_ch.valid && in_ch.ready && in_ch.mode == gdr_pkg::MODE_CAST) ? 1 : 0)
                    - ((out_ch.valid && out_ch.ready) ? 1 : 0);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 30000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Sends one beat and waits for it to be taken; valid is left high.
  task automatic send_beat(logic mode, logic [5:0] r, logic [5:0] c, logic wall,
                           logic [9:0] col);
    if (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.cell_row  <= r;
    in_ch.cell_col  <= c;
    in_ch.cell_wall <= wall;
    in_ch.column    <= col;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic put_wall(logic [5:0] r, logic [5:0] c, logic wall);
    send_beat(gdr_pkg::MODE_WRITE, r, c, wall, 10'($urandom));
  endtask

  task automatic put_cast(logic [9:0] col);
    send_beat(gdr_pkg::MODE_CAST, 6'($urandom), 6'($urandom), 1'($urandom), col);
  endtask

  // Drains the block before register writes.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (casts_open != 0 || slices_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes a whole camera setting; write enable is dropped once at the end.
  task automatic set_camera(logic [21:0] px, logic [21:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] qx, logic [15:0] qy,
                            logic [9:0] w, logic [9:0] h);
    logic [21:0] vals [8];
    logic [2:0]  idx [8];
    vals = '{px, py, {6'd0, dx}, {6'd0, dy}, {6'd0, qx}, {6'd0, qy}, {12'd0, w}, {12'd0, h}};
    idx  = '{gdr_pkg::CFG_POS_X, gdr_pkg::CFG_POS_Y, gdr_pkg::CFG_DIR_X,
             gdr_pkg::CFG_DIR_Y, gdr_pkg::CFG_PLANE_X, gdr_pkg::CFG_PLANE_Y,
             gdr_pkg::CFG_SCREEN_W, gdr_pkg::CFG_SCREEN_H};
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_w  = (w == 0) ? 10'd1 : w;
  endtask

  function automatic logic [15:0] pick_q14();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_dim();
    case ($urandom_range(5))
      0:       return 10'd0;
      1:       return 10'd1;
      2:       return 10'd1023;
      default: return 10'($urandom_range(1023, 16));
    endcase
  endfunction

  initial begin
    logic [21:0] px, py;
    rst_n           = 1'b0;
    calm            = 1'b0;
    cur_w           = 10'd320;
    cfg_we          = 1'b0;
    cfg_index       = gdr_pkg::CFG_POS_X;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = gdr_pkg::MODE_WRITE;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    in_ch.cell_wall = 1'b0;
    in_ch.column    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner walls, column extremes on the reset camera.
    put_cast(10'd0);
    put_wall(6'd0, 6'd0, 1'b1);
    put_wall(6'd63, 6'd63, 1'b1);
    put_wall(6'd2, 6'd0, 1'b1);
    put_wall(6'd2, 6'd5, 1'b1);
    put_cast(10'd0);
    put_cast(10'd160);
    put_cast(10'd319);
    put_cast(10'd1023);
    put_wall(6'd2, 6'd0, 1'b0);
    put_cast(10'd160);
    // Zero ray components, zero width and height, extreme positions.
    set_camera(22'd0, 22'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0);
    put_cast(10'd0);
    put_cast(10'd1023);
    set_camera(22'h3FFFFF, 22'h3FFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
               10'd1023, 10'd1023);
    put_cast(10'd0);
    put_cast(10'd1023);
    put_wall(6'd63, 6'd62, 1'b1);
    put_cast(10'd512);
    set_camera(22'h010000, 22'h010000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
               10'd1, 10'd1);
    put_cast(10'd0);
    put_cast(10'd1);
    // Distance zero: viewer on a boundary looking across it into a wall.
    put_wall(6'd1, 6'd0, 1'b1);
    set_camera(22'h010000, 22'h010000, 16'hC000, 16'h0000, 16'h0000, 16'h0000,
               10'd320, 10'd240);
    put_cast(10'd160);

    // Random phases: new camera each time, mostly casts over a partly walled map.
    for (int ph = 0; ph < 11; ph++) begin
      calm = (ph == 4);
      px = (ph == 2) ? 22'd0 : (ph == 3) ? 22'h3FFFFF : 22'($urandom);
      py = (ph == 2) ? 22'h3FFFFF : (ph == 3) ? 22'd0 : 22'($urandom);
      set_camera(px, py, pick_q14(), pick_q14(), pick_q14(), pick_q14(),
                 pick_dim(), pick_dim());
      for (int k = 0; k < 64; k++) begin
        if ($urandom_range(99) < 25)
          put_wall(6'($urandom), 6'($urandom), ($urandom_range(99) < 35));
        else if ($urandom_range(9) == 0)
          put_cast(10'($urandom));
        else
          put_cast(10'($urandom_range(cur_w - 1)));
      end
    end
    calm = 1'b0;

    // Drain and give the verdict.
    settle();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && slices_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gdr_pkg.sv
hw/rtl/gdr_in_if.sv
hw/rtl/gdr_out_if.sv
hw/rtl/gdr_ram.sv
hw/rtl/gdr_div.sv
hw/rtl/grid_dda_raycaster_top.sv
test/gdr_slice_checker.sv
test/tb_top.sv
